@@ src/cbm_pkg.sv @@
// shared types and constants of the cartridge bank mapper
// used by cbm_decode and cartridge_bank_mapper; no dependencies

package cbm_pkg;

  localparam int RAM_BYTES = 8192;
  localparam int RAM_AW    = $clog2(RAM_BYTES);

  localparam int ROM_AW    = 21;
  localparam int BANK_W    = 7;
  localparam int OFFS_W    = 14;

  // bus regions, address bits 15:13
  localparam logic [2:0] RGN_RAMEN = 3'd0;
  localparam logic [2:0] RGN_LOW   = 3'd1;
  localparam logic [2:0] RGN_HIGH  = 3'd2;
  localparam logic [2:0] RGN_MODE  = 3'd3;
  localparam logic [2:0] RGN_VRAM  = 3'd4;
  localparam logic [2:0] RGN_CART  = 3'd5;
  localparam logic [2:0] RGN_WRAM  = 3'd6;
  localparam logic [2:0] RGN_ECHO  = 3'd7;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_ROM  = 2'd1;
  localparam logic [1:0] SRC_CART = 2'd2;
  localparam logic [1:0] SRC_WRAM = 2'd3;

  localparam logic [3:0] RAMEN_KEY  = 4'hA;
  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] MASK_NOBNK = 8'h7F;

  // configuration register indexes
  localparam logic REG_ROM_CNT = 1'b0;
  localparam logic REG_RAM_CNT = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
  } cbm_in_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  source;
    logic [20:0] rom_address;
    logic [7:0]  read_byte;
  } cbm_out_t;

  typedef struct packed {
    logic       ram_en;
    logic       mode;
    logic [4:0] low_bank;
    logic [1:0] high_bank;
  } cbm_latch_t;

  typedef struct packed {
    logic              hit;
    logic [1:0]        source;
    logic [ROM_AW-1:0] rom_address;
    logic              sel_cart;
    logic              sel_work;
  } cbm_meta_t;

  typedef struct packed {
    logic cart_we;
    logic work_we;
  } cbm_ramop_t;

endpackage

@@ src/cbm_ram.sv @@
// generic single-port synchronous ram with registered read
// no dependencies

module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/cbm_decode.sv @@
// bus access decode: latch updates, rom bank translation, ram controls
// depends on cbm_pkg

module cbm_decode
  import cbm_pkg::*;
(
  input  cbm_in_t    item,
  input  cbm_latch_t latch,
  input  logic [7:0] rom_cnt,
  input  logic       ram_cnt,
  output cbm_latch_t latch_nxt,
  output cbm_meta_t  meta,
  output cbm_ramop_t ramop
);

  logic [2:0]        region;
  logic [7:0]        mask;
  logic [BANK_W-1:0] bank;
  logic              cart_ok;

  assign region  = item.bus_address[15:13];
  assign mask    = (rom_cnt == 8'd0) ? MASK_NOBNK : rom_cnt - 8'd1;
  assign cart_ok = latch.ram_en & ram_cnt;

  always_comb begin
    bank = '0;
    if (region == RGN_RAMEN || region == RGN_LOW) begin
      if (latch.mode && rom_cnt != 8'd0) begin
        bank = {latch.high_bank, 5'd0} & mask[BANK_W-1:0];
      end
    end else begin
      bank = {latch.high_bank, latch.low_bank[4:1],
              latch.low_bank[0] | (latch.low_bank == 5'd0)} & mask[BANK_W-1:0];
    end
  end

  always_comb begin
    latch_nxt = latch;
    ramop     = '0;
    meta      = '0;
    if (item.op == OP_WRITE) begin
      case (region)
        RGN_RAMEN: latch_nxt.ram_en = (item.write_byte[3:0] == RAMEN_KEY);
        RGN_LOW:   latch_nxt.low_bank = item.write_byte[4:0];
        RGN_HIGH:  latch_nxt.high_bank = item.write_byte[1:0];
        RGN_MODE:  latch_nxt.mode = item.write_byte[0];
        RGN_CART:  ramop.cart_we = cart_ok;
        RGN_WRAM, RGN_ECHO: ramop.work_we = 1'b1;
        default: ;
      endcase
    end else begin
      case (region)
        RGN_RAMEN, RGN_LOW, RGN_HIGH, RGN_MODE: begin
          meta.hit         = 1'b1;
          meta.source      = SRC_ROM;
          meta.rom_address = {bank, item.bus_address[OFFS_W-1:0]};
        end
        RGN_CART: begin
          meta.hit      = 1'b1;
          meta.source   = SRC_CART;
          meta.sel_cart = cart_ok;
        end
        RGN_WRAM, RGN_ECHO: begin
          meta.hit      = 1'b1;
          meta.source   = SRC_WRAM;
          meta.sel_work = 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/cartridge_bank_mapper.sv @@
// cartridge bank mapper top level: banking latches, config port, two rams
// pipeline: an accepted item is held in the s1 registers, then in the output register
// throughput: one item per cycle while in_stall is low, set by the single ram port per access
// reset: latches and config clear; a clearing pass zeroes all 8192 bytes of both
// rams, during which in_stall is high (config writes still taken)
// depends on cbm_pkg, cbm_decode, cbm_ram

module cartridge_bank_mapper
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  cbm_in_t     in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output cbm_out_t    out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [RAM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [7:0]        rom_cnt_r;
  logic              ram_cnt_r;
  cbm_latch_t        latch_r, latch_nxt;
  cbm_meta_t         meta, s1_meta_r;
  cbm_ramop_t        ramop;
  logic              s1_v_r, s1_adv, accept, clearing;
  logic              out_v_r;
  cbm_out_t          out_item_r;
  logic [RAM_AW-1:0] mem_addr;
  logic [7:0]        ram_wdata, cart_rdata, work_rdata;
  logic              cart_en, cart_we, work_en, work_we;
  logic              cfg_wr;

  assign clearing = (state_r == ST_CLEAR);
  assign in_stall = clearing || (s1_v_r && out_v_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign s1_adv   = s1_v_r && (!out_v_r || !out_stall);

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_RAM_CNT) ? {31'd0, ram_cnt_r}
                                                    : {24'd0, rom_cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_cnt_r <= '0;
      ram_cnt_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ROM_CNT) begin
        rom_cnt_r <= cfg_pwdata[7:0];
      end else begin
        ram_cnt_r <= cfg_pwdata[0];
      end
    end
  end

  cbm_decode u_decode (
    .item      (in_item),
    .latch     (latch_r),
    .rom_cnt   (rom_cnt_r),
    .ram_cnt   (ram_cnt_r),
    .latch_nxt (latch_nxt),
    .meta      (meta),
    .ramop     (ramop)
  );

  // clearing sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + RAM_AW'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: ;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // ram port muxing
  assign mem_addr  = clearing ? clr_cnt_r : in_item.bus_address[RAM_AW-1:0];
  assign ram_wdata = clearing ? 8'd0 : in_item.write_byte;
  assign cart_we   = clearing || (accept && ramop.cart_we);
  assign work_we   = clearing || (accept && ramop.work_we);
  assign cart_en   = cart_we || (accept && meta.sel_cart);
  assign work_en   = work_we || (accept && meta.sel_work);

  cbm_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_cart_ram (
    .clk   (clk),
    .en    (cart_en),
    .we    (cart_we),
    .addr  (mem_addr),
    .wdata (ram_wdata),
    .rdata (cart_rdata)
  );

  cbm_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_work_ram (
    .clk   (clk),
    .en    (work_en),
    .we    (work_we),
    .addr  (mem_addr),
    .wdata (ram_wdata),
    .rdata (work_rdata)
  );

  // latches and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        latch_r <= latch_nxt;
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
    end
    if (s1_adv) begin
      out_item_r.hit         <= s1_meta_r.hit;
      out_item_r.source      <= s1_meta_r.source;
      out_item_r.rom_address <= s1_meta_r.rom_address;
      out_item_r.read_byte   <= s1_meta_r.sel_cart ? cart_rdata :
                                s1_meta_r.sel_work ? work_rdata : BYTE_IDLE;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  // checks
  a_hit_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_item_r.hit == (out_item_r.source != SRC_NONE)))
    else $error("hit flag disagrees with source");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(s1_meta_r)))
    else $error("held pipeline item was lost or changed");

  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    (clearing && clr_cnt_r != '1) |=> clearing)
    else $error("ram clearing pass ended early");

  a_no_s1_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !s1_v_r && !out_v_r)
    else $error("item in flight during ram clearing");

endmodule
